// File: rtl/core/text_line_folder_defines.svh
// Assertion macros for the checker file of the line folder.
`ifndef TEXT_LINE_FOLDER_DEFINES_SVH
`define TEXT_LINE_FOLDER_DEFINES_SVH

// Same-cycle implication, sampled on aclk and off while aresetn is low.
`define TLF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk and off while aresetn is low.
`define TLF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/tlf_pkg.sv
`default_nettype none

package tlf_pkg;

    localparam int CHAR_W    = 8;
    localparam int COL_W     = 6;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TAB_WIDTH  = 1'd1;

    localparam logic [COL_W-1:0] LINE_WIDTH_RST = 6'd20;
    localparam logic [COL_W-1:0] TAB_WIDTH_RST  = 6'd4;

    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_ADV,
        ST_NL,
        ST_READ,
        ST_CHAR,
        ST_BLANK
    } state_t;

    // One output character request from the sequencer.
    typedef struct packed {
        logic              valid;
        logic [CHAR_W-1:0] data;
        logic              last;
    } emit_t;

endpackage

`default_nettype wire

// File: rtl/core/tlf_col_unit.sv
`default_nettype none

// Shared adder and limit compare: sum = a + b, gt = sum > limit.
module tlf_col_unit (
    input  wire logic [tlf_pkg::COL_W-1:0] a,
    input  wire logic [tlf_pkg::COL_W-1:0] b,
    input  wire logic [tlf_pkg::COL_W-1:0] limit,
    output logic      [tlf_pkg::COL_W:0]   sum,
    output logic                           gt
);

    always_comb begin
        sum = {1'b0, a} + {1'b0, b};
        gt  = sum > {1'b0, limit};
    end

endmodule

`default_nettype wire

// File: rtl/core/tlf_word_buf.sv
`default_nettype none

module tlf_word_buf #(
    parameter int DEPTH = 32,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic                       aclk,
    input  wire logic                       wr_en,
    input  wire logic [AW-1:0]              wr_addr,
    input  wire logic [tlf_pkg::CHAR_W-1:0] wr_data,
    input  wire logic [AW-1:0]              rd_addr,
    output logic      [tlf_pkg::CHAR_W-1:0] rd_data
);

    logic [tlf_pkg::CHAR_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// File: rtl/core/tlf_ctrl.sv
`default_nettype none

module tlf_ctrl #(
    parameter int MAX_WIDTH = 32,
    localparam int AW = $clog2(MAX_WIDTH),
    localparam int LW = $clog2(MAX_WIDTH + 1)
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [tlf_pkg::CHAR_W-1:0]  in_char,
    input  wire logic                        in_eoi,
    input  wire logic [tlf_pkg::COL_W-1:0]   tab_width,
    input  wire logic                        out_free,
    output logic      [tlf_pkg::COL_W-1:0]   unit_a,
    output logic      [tlf_pkg::COL_W-1:0]   unit_b,
    input  wire logic [tlf_pkg::COL_W:0]     unit_sum,
    input  wire logic                        unit_gt,
    output logic                             buf_wr_en,
    output logic      [AW-1:0]               buf_wr_addr,
    output logic      [tlf_pkg::CHAR_W-1:0]  buf_wr_data,
    output logic      [AW-1:0]               buf_rd_addr,
    input  wire logic [tlf_pkg::CHAR_W-1:0]  buf_rd_data,
    output tlf_pkg::emit_t                   emit
);

    tlf_pkg::state_t state_reg, state_next;

    logic [tlf_pkg::CHAR_W-1:0] ch_reg, ch_next;
    logic                       eoi_reg, eoi_next;
    logic [LW-1:0]              wl_reg, wl_next;
    logic [tlf_pkg::COL_W-1:0]  col_reg, col_next;
    logic [AW-1:0]              idx_reg, idx_next;
    logic                       adv_word_reg, adv_word_next;

    logic                       is_space, is_tab, is_nl, blank_follow;
    logic                       flush, idx_last;
    logic [tlf_pkg::COL_W-1:0]  wl_ext, adv_n;

    always_comb begin
        is_space     = ch_reg == tlf_pkg::CH_SPACE;
        is_tab       = ch_reg == tlf_pkg::CH_TAB;
        is_nl        = ch_reg == tlf_pkg::CH_NL;
        blank_follow = !eoi_reg && (is_space || is_tab || is_nl);
        wl_ext       = tlf_pkg::COL_W'(wl_reg);
        adv_n        = adv_word_reg ? wl_ext
                                    : (is_space ? tlf_pkg::COL_W'(1) : tab_width);
        // In the check step the shared unit tests wl + 1 > limit, i.e. a word as long as the line limit.
        unit_a       = (state_reg == tlf_pkg::ST_CHECK) ? wl_ext : col_reg;
        unit_b       = (state_reg == tlf_pkg::ST_CHECK) ? tlf_pkg::COL_W'(1) : adv_n;
        flush        = (wl_reg != '0) && (eoi_reg || blank_follow || unit_gt);
        idx_last     = (LW'(idx_reg) + LW'(1)) == wl_reg;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            tlf_pkg::ST_IDLE: begin
                if (in_valid) begin
                    state_next = tlf_pkg::ST_CHECK;
                end
            end
            tlf_pkg::ST_CHECK: begin
                if (flush) begin
                    state_next = tlf_pkg::ST_ADV;
                end else if (eoi_reg) begin
                    state_next = tlf_pkg::ST_IDLE;
                end else if (is_nl) begin
                    state_next = tlf_pkg::ST_BLANK;
                end else if (is_space || is_tab) begin
                    state_next = tlf_pkg::ST_ADV;
                end else begin
                    state_next = tlf_pkg::ST_IDLE;
                end
            end
            tlf_pkg::ST_ADV: begin
                if (unit_gt) begin
                    state_next = tlf_pkg::ST_NL;
                end else begin
                    state_next = adv_word_reg ? tlf_pkg::ST_READ : tlf_pkg::ST_BLANK;
                end
            end
            tlf_pkg::ST_NL: begin
                if (out_free) begin
                    state_next = adv_word_reg ? tlf_pkg::ST_READ : tlf_pkg::ST_BLANK;
                end
            end
            tlf_pkg::ST_READ: begin
                state_next = tlf_pkg::ST_CHAR;
            end
            tlf_pkg::ST_CHAR: begin
                if (out_free) begin
                    // After the word, the check step runs again to handle the character.
                    state_next = idx_last ? tlf_pkg::ST_CHECK : tlf_pkg::ST_READ;
                end
            end
            tlf_pkg::ST_BLANK: begin
                if (out_free) begin
                    state_next = tlf_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = tlf_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        in_ready      = 1'b0;
        emit          = '0;
        buf_wr_en     = 1'b0;
        buf_wr_addr   = wl_reg[AW-1:0];
        buf_wr_data   = ch_reg;
        buf_rd_addr   = idx_reg;
        ch_next       = ch_reg;
        eoi_next      = eoi_reg;
        wl_next       = wl_reg;
        col_next      = col_reg;
        idx_next      = idx_reg;
        adv_word_next = adv_word_reg;
        case (state_reg)
            tlf_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    ch_next  = in_char;
                    eoi_next = in_eoi;
                end
            end
            tlf_pkg::ST_CHECK: begin
                if (flush) begin
                    adv_word_next = 1'b1;
                    idx_next      = '0;
                end else if (!eoi_reg && !blank_follow) begin
                    if (wl_reg < LW'(MAX_WIDTH)) begin
                        buf_wr_en = 1'b1;
                        wl_next   = wl_reg + LW'(1);
                    end
                end else if (is_space || is_tab) begin
                    adv_word_next = 1'b0;
                end
            end
            tlf_pkg::ST_ADV: begin
                col_next = unit_gt ? adv_n : unit_sum[tlf_pkg::COL_W-1:0];
            end
            tlf_pkg::ST_NL: begin
                if (out_free) begin
                    emit = '{valid: 1'b1, data: tlf_pkg::CH_NL, last: 1'b0};
                end
            end
            tlf_pkg::ST_CHAR: begin
                if (out_free) begin
                    emit = '{valid: 1'b1, data: buf_rd_data,
                             last: idx_last && !blank_follow};
                    if (idx_last) begin
                        wl_next = '0;
                    end else begin
                        idx_next = idx_reg + AW'(1);
                    end
                end
            end
            tlf_pkg::ST_BLANK: begin
                if (out_free) begin
                    emit = '{valid: 1'b1, data: ch_reg, last: 1'b1};
                    if (is_nl) begin
                        col_next = '0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tlf_pkg::ST_IDLE;
            wl_reg    <= '0;
            col_reg   <= '0;
        end else begin
            state_reg <= state_next;
            wl_reg    <= wl_next;
            col_reg   <= col_next;
        end
    end

    always_ff @(posedge aclk) begin
        ch_reg       <= ch_next;
        eoi_reg      <= eoi_next;
        idx_reg      <= idx_next;
        adv_word_reg <= adv_word_next;
    end

endmodule

`default_nettype wire

// File: rtl/core/text_line_folder.sv
// A request is taken only while the block is idle, so each is done before the next.
// A word flush reads its characters one by one from the word buffer, which has one
// read port and a registered read.
// Reset (aresetn low, synchronous): no pending word, column 0, line_width 20,
// tab_width 4, output empty. The word buffer itself is not cleared.
`default_nettype none

module text_line_folder #(
    parameter int MAX_WIDTH = 32  // longest word held, 2 to 60
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [7:0]                     s_tdata,   // [7:0] in_char
    input  wire logic                           s_tuser,   // [0] end_of_input
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic      [7:0]                     m_tdata,   // [7:0] out_char
    output logic                                m_tlast,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [tlf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [tlf_pkg::COL_W-1:0]      cfg_data
);

    localparam int AW = $clog2(MAX_WIDTH);

    logic [tlf_pkg::COL_W-1:0]  lw_reg, lw_next;
    logic [tlf_pkg::COL_W-1:0]  tw_reg, tw_next;
    logic [tlf_pkg::COL_W-1:0]  limit;

    logic                       m_valid_reg, m_valid_next;
    logic [tlf_pkg::CHAR_W-1:0] m_data_reg, m_data_next;
    logic                       m_last_reg, m_last_next;
    logic                       out_free;

    logic [tlf_pkg::COL_W-1:0]  unit_a, unit_b;
    logic [tlf_pkg::COL_W:0]    unit_sum;
    logic                       unit_gt;

    logic                       buf_wr_en;
    logic [AW-1:0]              buf_wr_addr, buf_rd_addr;
    logic [tlf_pkg::CHAR_W-1:0] buf_wr_data, buf_rd_data;

    tlf_pkg::emit_t             emit;

    assign cfg_ready = 1'b1;

    always_comb begin
        lw_next = lw_reg;
        tw_next = tw_reg;
        if (cfg_valid) begin
            case (cfg_index)
                tlf_pkg::REG_LINE_WIDTH: lw_next = cfg_data;
                tlf_pkg::REG_TAB_WIDTH:  tw_next = cfg_data;
                default: begin
                end
            endcase
        end
    end

    // The effective limit is line_width held within 1 and MAX_WIDTH.
    always_comb begin
        if (lw_reg == '0) begin
            limit = tlf_pkg::COL_W'(1);
        end else if (lw_reg > tlf_pkg::COL_W'(MAX_WIDTH)) begin
            limit = tlf_pkg::COL_W'(MAX_WIDTH);
        end else begin
            limit = lw_reg;
        end
    end

    always_comb begin
        out_free     = !m_valid_reg || m_tready;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;
        if (emit.valid) begin
            m_valid_next = 1'b1;
            m_data_next  = emit.data;
            m_last_next  = emit.last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lw_reg      <= tlf_pkg::LINE_WIDTH_RST;
            tw_reg      <= tlf_pkg::TAB_WIDTH_RST;
            m_valid_reg <= 1'b0;
        end else begin
            lw_reg      <= lw_next;
            tw_reg      <= tw_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    tlf_col_unit u_col_unit (
        .a     (unit_a),
        .b     (unit_b),
        .limit (limit),
        .sum   (unit_sum),
        .gt    (unit_gt)
    );

    tlf_word_buf #(
        .DEPTH (MAX_WIDTH)
    ) u_word_buf (
        .aclk    (aclk),
        .wr_en   (buf_wr_en),
        .wr_addr (buf_wr_addr),
        .wr_data (buf_wr_data),
        .rd_addr (buf_rd_addr),
        .rd_data (buf_rd_data)
    );

    tlf_ctrl #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_char     (s_tdata),
        .in_eoi      (s_tuser),
        .tab_width   (tw_reg),
        .out_free    (out_free),
        .unit_a      (unit_a),
        .unit_b      (unit_b),
        .unit_sum    (unit_sum),
        .unit_gt     (unit_gt),
        .buf_wr_en   (buf_wr_en),
        .buf_wr_addr (buf_wr_addr),
        .buf_wr_data (buf_wr_data),
        .buf_rd_addr (buf_rd_addr),
        .buf_rd_data (buf_rd_data),
        .emit        (emit)
    );

endmodule

`default_nettype wire

// File: rtl/core/tlf_checker.sv
`default_nettype none
`include "text_line_folder_defines.svh"

module tlf_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_tvalid,
    input wire logic       s_tready,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic       m_tlast
);

    // The block works on one request at a time.
    `TLF_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "accepted while busy")

    // A new result is only produced while no request is being taken.
    `TLF_ASSERT_NOW(a_emit_when_busy, $rose(m_tvalid), $past(!s_tready), "result from idle")

    // A space or tab closes the output of its request.
    `TLF_ASSERT_NOW(a_blank_is_last,
        m_tvalid && (m_tdata == tlf_pkg::CH_SPACE || m_tdata == tlf_pkg::CH_TAB),
        m_tlast, "blank not marked last")

    // A stalled result holds.
    `TLF_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled result changed")

endmodule

bind text_line_folder tlf_checker u_tlf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire

// File: tb/text_line_folder_tb.sv
module text_line_folder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FOLD_MAX    = 32;
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int SETTLE      = 20;
    localparam int TAIL        = 50;

    typedef struct packed {
        logic [tlf_pkg::CHAR_W-1:0] ch;
        logic                       eoi;
    } text_req_t;

    typedef struct packed {
        logic [tlf_pkg::CHAR_W-1:0] ch;
        logic                       last;
    } fold_res_t;

    logic                          aclk      = 1'b0;
    logic                          aresetn   = 1'b0;
    logic                          s_tvalid  = 1'b0;
    logic                          s_tready;
    logic [7:0]                    s_tdata   = '0;  // [7:0] in_char
    logic                          s_tuser   = 1'b0;  // [0] end_of_input
    logic                          m_tvalid;
    logic                          m_tready  = 1'b0;
    logic [7:0]                    m_tdata;         // [7:0] out_char
    logic                          m_tlast;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [tlf_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [tlf_pkg::COL_W-1:0]     cfg_data  = '0;

    text_line_folder #(.MAX_WIDTH(FOLD_MAX)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Predicted state of the folder.
    logic [tlf_pkg::CHAR_W-1:0] word_buf [FOLD_MAX];
    int                         word_len;
    int                         col;
    logic [tlf_pkg::COL_W-1:0]  line_w;
    logic [tlf_pkg::COL_W-1:0]  tab_w;

    text_req_t pending_reqs[$];
    fold_res_t step_out[$];
    fold_res_t expected_chars[$];

    int  fail_count = 0;
    int  cycles     = 0;
    logic in_taken  = 1'b0;
    int  in_gap     = 0;
    int  out_stall  = 0;
    bit  in_calm    = 1'b0;
    bit  out_calm   = 1'b0;

    function automatic int fold_limit();
        int w;
        w = int'(line_w);
        if (w < 1) w = 1;
        if (w > FOLD_MAX) w = FOLD_MAX;
        return w;
    endfunction

    function automatic void put_char(input logic [tlf_pkg::CHAR_W-1:0] c);
        fold_res_t r;
        r.ch = c;
        r.last = 1'b0;
        step_out.push_back(r);
    endfunction

    // The sum is compared unwrapped; only the stored column is cut to 6 bits.
    function automatic void move_col(input int n);
        int sum;
        sum = col + n;
        if (sum > fold_limit()) begin
            put_char(tlf_pkg::CH_NL);
            sum = n;
        end
        col = sum & 63;
    endfunction

    function automatic void flush_word();
        if (word_len == 0) return;
        move_col(word_len);
        for (int i = 0; i < word_len && i < FOLD_MAX; i++) put_char(word_buf[i]);
        word_len = 0;
    endfunction

    function automatic void fold_step(input text_req_t r);
        step_out.delete();
        if (r.eoi) begin
            flush_word();
        end else if (r.ch == tlf_pkg::CH_SPACE || r.ch == tlf_pkg::CH_TAB
                     || r.ch == tlf_pkg::CH_NL) begin
            flush_word();
            if (r.ch == tlf_pkg::CH_NL) begin
                put_char(tlf_pkg::CH_NL);
                col = 0;
            end else if (r.ch == tlf_pkg::CH_SPACE) begin
                move_col(1);
                put_char(tlf_pkg::CH_SPACE);
            end else begin
                move_col(int'(tab_w));
                put_char(tlf_pkg::CH_TAB);
            end
        end else begin
            if (word_len >= fold_limit()) flush_word();
            if (word_len < FOLD_MAX) begin
                word_buf[word_len] = r.ch;
                word_len++;
            end
        end
        if (step_out.size() > 0) step_out[step_out.size()-1].last = 1'b1;
        foreach (step_out[i]) expected_chars.push_back(step_out[i]);
    endfunction

    // Mostly short gaps, a few long ones, none at all while calm.
    function automatic int draw_gap(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(negedge aclk) begin : drive_in
        text_req_t nxt;
        logic v;
        v = s_tvalid;
        if (!aresetn) begin
            v = 1'b0;
        end else if (!s_tvalid || in_taken) begin
            if (in_gap > 0) begin
                v = 1'b0;
                in_gap--;
            end else if (pending_reqs.size() > 0) begin
                nxt = pending_reqs.pop_front();
                s_tdata <= nxt.ch;
                s_tuser <= nxt.eoi;
                v = 1'b1;
                if ($urandom_range(0, 49) == 0) in_calm = !in_calm;
                in_gap = draw_gap(in_calm);
            end else begin
                v = 1'b0;
            end
        end
        s_tvalid <= v;
    end

    always @(negedge aclk) begin : drive_out
        if (out_stall > 0) begin
            m_tready <= 1'b0;
            out_stall--;
        end else begin
            m_tready <= 1'b1;
            if ($urandom_range(0, 49) == 0) out_calm = !out_calm;
            if ($urandom_range(0, 99) < 30) out_stall = draw_gap(out_calm);
        end
    end

    always @(posedge aclk) begin : watch
        fold_res_t want;
        text_req_t got;
        cycles++;
        in_taken <= aresetn && s_tvalid && s_tready;
        if (cycles >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else if (!aresetn) begin
            word_len = 0;
            col = 0;
            line_w = tlf_pkg::LINE_WIDTH_RST;
            tab_w = tlf_pkg::TAB_WIDTH_RST;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_chars.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected output: char %h last %b", m_tdata, m_tlast);
                end else begin
                    want = expected_chars.pop_front();
                    if (m_tdata !== want.ch || m_tlast !== want.last) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: char %h last %b, expected char %h last %b",
                                     m_tdata, m_tlast, want.ch, want.last);
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    tlf_pkg::REG_LINE_WIDTH: line_w = cfg_data;
                    tlf_pkg::REG_TAB_WIDTH:  tab_w = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                got.ch = s_tdata;
                got.eoi = s_tuser;
                fold_step(got);
            end
        end
    end

    task automatic queue_req(input logic [7:0] c, input logic e);
        text_req_t r;
        r.ch = c;
        r.eoi = e;
        pending_reqs.push_back(r);
    endtask

    task automatic queue_text(input string s);
        for (int i = 0; i < s.len(); i++) queue_req(s[i], 1'b0);
    endtask

    // Waits until every request is taken and every result is out, then lets
    // a word that causes no result finish inside the block.
    task automatic drain();
        @(posedge aclk);
        while (pending_reqs.size() != 0 || s_tvalid || expected_chars.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [tlf_pkg::CFG_IDX_W-1:0] idx,
                             input logic [tlf_pkg::COL_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_fold(input logic [tlf_pkg::COL_W-1:0] lw,
                            input logic [tlf_pkg::COL_W-1:0] tw);
        drain();
        write_reg(tlf_pkg::REG_LINE_WIDTH, lw);
        write_reg(tlf_pkg::REG_TAB_WIDTH, tw);
    endtask

    // Mostly words with separators, some stray bytes and end marks.
    task automatic gen_text(input int count);
        int n;
        int len;
        int r;
        logic [7:0] c;
        n = 0;
        while (n < count) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
                queue_req(8'($urandom_range(0, 255)), 1'b0);
                n++;
            end else if (r < 12) begin
                queue_req(8'($urandom_range(0, 255)), 1'b1);
                n++;
            end else begin
                len = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 8) : $urandom_range(1, 40);
                for (int i = 0; i < len; i++) begin
                    if ($urandom_range(0, 99) < 85) begin
                        c = 8'($urandom_range(8'h21, 8'h7E));
                    end else begin
                        do c = 8'($urandom_range(0, 255));
                        while (c == tlf_pkg::CH_SPACE || c == tlf_pkg::CH_TAB
                               || c == tlf_pkg::CH_NL);
                    end
                    queue_req(c, 1'b0);
                end
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    queue_req(tlf_pkg::CH_SPACE, 1'b0);
                end else if (r < 82) begin
                    queue_req(tlf_pkg::CH_TAB, 1'b0);
                end else if (r < 94) begin
                    queue_req(tlf_pkg::CH_NL, 1'b0);
                end else begin
                    queue_req(tlf_pkg::CH_SPACE, 1'b0);
                    queue_req(tlf_pkg::CH_SPACE, 1'b0);
                end
                n += len + 1;
            end
        end
    endtask

    initial begin
        logic [tlf_pkg::COL_W-1:0] lw;
        logic [tlf_pkg::COL_W-1:0] tw;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;

        // Reset widths: NUL and high bytes as letters, every blank, end marks.
        queue_text("hi");
        queue_req(8'h00, 1'b0);
        queue_req(8'hFF, 1'b0);
        queue_req(tlf_pkg::CH_SPACE, 1'b0);
        queue_req(tlf_pkg::CH_TAB, 1'b0);
        queue_req(tlf_pkg::CH_NL, 1'b0);
        queue_text("z");
        queue_req(8'hFF, 1'b1);
        queue_req(8'h00, 1'b1);

        // Narrow lines: forced word break, a tab wider than the line.
        set_fold(6'd3, 6'd63);
        queue_text("abcd");
        queue_req(tlf_pkg::CH_TAB, 1'b0);
        queue_req(tlf_pkg::CH_SPACE, 1'b0);

        // Zero-width tab, then a word left pending across a width change.
        set_fold(6'd32, 6'd0);
        queue_req(tlf_pkg::CH_TAB, 1'b0);
        queue_text("abcdef");

        // A zero width clamps to one; the pending word breaks even at column 0.
        set_fold(6'd0, 6'd32);
        queue_text("g");
        queue_req(8'h41, 1'b1);

        for (int p = 0; p < 6; p++) begin
            if (p == 0) begin
                lw = 6'd63;
                tw = 6'd1;
            end else begin
                if ($urandom_range(0, 99) < 30) begin
                    case ($urandom_range(0, 3))
                        0: lw = 6'd0;
                        1: lw = 6'd1;
                        2: lw = 6'd32;
                        default: lw = 6'd63;
                    endcase
                end else begin
                    lw = 6'($urandom_range(2, 31));
                end
                if ($urandom_range(0, 99) < 30) begin
                    case ($urandom_range(0, 3))
                        0: tw = 6'd0;
                        1: tw = 6'd1;
                        2: tw = 6'd32;
                        default: tw = 6'd63;
                    endcase
                end else begin
                    tw = 6'($urandom_range(1, 8));
                end
            end
            set_fold(lw, tw);
            gen_text(8);
            if ($urandom_range(0, 1) == 1) queue_req(8'($urandom_range(0, 255)), 1'b1);
        end

        drain();
        repeat (TAIL) @(posedge aclk);
        if (fail_count == 0 && expected_chars.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
